### design/i2cms_pkg.sv
package i2cms_pkg;

    // command codes carried on the input channel
    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ      = 3'd3,
        CMD_WAIT_ACK  = 3'd4,
        CMD_SEND_ACK  = 3'd5,
        CMD_SEND_NACK = 3'd6
    } t_cmd;

    // configuration register indexes
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 10;
    localparam logic [CfgIdxW-1:0] CFG_UNIT_TICKS  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 1'b1;

    // reset values of the configuration registers
    localparam logic [9:0] UNIT_TICKS_RST  = 10'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // one tick item
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       read_ack;
        logic       sda_in;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_en;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_out_item;

endpackage

### design/i2cms_in_if.sv
interface i2cms_in_if;
    import i2cms_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/i2cms_out_if.sv
interface i2cms_out_if;
    import i2cms_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/i2c_master_byte_sequencer.sv
// I2C master byte sequencer. Each input transfer is one bus timing tick and yields exactly one
// result transfer with the SCL level, SDA level and SDA drive enable after that tick, plus busy,
// a one-tick done pulse, the last received byte and the acknowledge error flag. A tick with
// cmd_valid set while idle starts start, stop, write, read, wait-ack, send-ack or send-nack;
// commands while busy and code 7 are dropped. Bus segments last 1, 2 or 4 units of unit_ticks
// ticks (0 counts as 1); a wait-ack that sees SDA high for more than ack_timeout polls issues a
// stop and sets ack_error. The block takes one tick per clock: the full step is one pass of
// logic from the state registers into the output register, so a new tick is accepted every cycle
// as long as the result register is empty or being drained in the same cycle. Configuration
// writes should only be made while the block is idle.
module i2c_master_byte_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    i2cms_in_if.sink                        i_in,
    i2cms_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [i2cms_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [i2cms_pkg::CfgDataW-1:0]  i_cfg_data
);
    import i2cms_pkg::*;

    typedef enum logic [14:0] {
        PH_IDLE = 15'b000000000000001,
        PH_ST_A = 15'b000000000000010,
        PH_ST_B = 15'b000000000000100,
        PH_SP_A = 15'b000000000001000,
        PH_SP_B = 15'b000000000010000,
        PH_WR_A = 15'b000000000100000,
        PH_WR_B = 15'b000000001000000,
        PH_WR_C = 15'b000000010000000,
        PH_RD_A = 15'b000000100000000,
        PH_RD_B = 15'b000001000000000,
        PH_AK_A = 15'b000010000000000,
        PH_AK_B = 15'b000100000000000,
        PH_WA_A = 15'b001000000000000,
        PH_WA_B = 15'b010000000000000,
        PH_WA_P = 15'b100000000000000
    } t_phase;

    // segment length as a shift of the unit count
    typedef enum logic [1:0] {
        LEN_1U = 2'd0,
        LEN_2U = 2'd1,
        LEN_4U = 2'd2
    } t_len;

    typedef struct packed {
        t_phase phase;
        logic   scl;
        logic   sda;
        logic   en;
        t_len   len;
    } t_seg;

    function automatic logic [11:0] f_seg_delay(input logic [9:0] unit, input t_len len);
        logic [11:0] u;
        u = (unit == 10'd0) ? 12'd1 : {2'b00, unit};
        return u << len;
    endfunction

    // configuration registers
    logic [9:0]  r_unit_ticks;
    logic [7:0]  r_ack_timeout;

    // sequencer state
    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [11:0] r_delay, n_delay;
    logic [7:0]  r_poll, n_poll;
    logic        r_ack_choice, n_ack_choice;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_en, n_en;
    logic        r_err, n_err;
    logic [7:0]  r_rx, n_rx;

    // result register
    logic        r_out_valid;
    t_out_item   r_out;

    logic        accept;
    logic        done;
    logic        seg_go;
    t_seg        seg_v;
    logic [11:0] delay_dec;
    logic [7:0]  rd_shift;
    logic [3:0]  bit_inc;

    // a new tick enters whenever the result register is free or draining
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign delay_dec = r_delay - 12'd1;
    assign rd_shift  = {r_shift[6:0], i_in.data.sda_in};
    assign bit_inc   = r_bit_cnt + 4'd1;

    // one sequencer step per accepted tick
    always_comb begin
        n_phase      = r_phase;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_en         = r_en;
        n_err        = r_err;
        n_rx         = r_rx;
        done         = 1'b0;
        seg_go       = 1'b0;
        seg_v        = '{PH_IDLE, 1'b1, 1'b1, 1'b1, LEN_1U};

        if (accept) begin
            if (r_phase == PH_IDLE) begin
                // command decode while idle
                if (i_in.data.cmd_valid) begin
                    n_bit_cnt = 4'd0;
                    n_poll    = 8'd0;
                    unique case (t_cmd'(i_in.data.cmd))
                        CMD_START: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_ST_A, 1'b1, 1'b1, 1'b1, LEN_4U};
                        end
                        CMD_STOP: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_SP_A, 1'b0, 1'b0, 1'b1, LEN_4U};
                        end
                        CMD_WRITE: begin
                            seg_go  = 1'b1;
                            seg_v   = '{PH_WR_A, 1'b0, i_in.data.tx_byte[7], 1'b1, LEN_2U};
                            n_shift = {i_in.data.tx_byte[6:0], 1'b0};
                        end
                        CMD_READ: begin
                            n_ack_choice = i_in.data.read_ack;
                            n_shift      = 8'd0;
                            seg_go       = 1'b1;
                            seg_v        = '{PH_RD_A, 1'b0, 1'b1, 1'b0, LEN_2U};
                        end
                        CMD_WAIT_ACK: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_WA_A, r_scl, 1'b1, 1'b0, LEN_1U};
                        end
                        CMD_SEND_ACK: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_AK_A, 1'b0, 1'b0, 1'b1, LEN_2U};
                        end
                        CMD_SEND_NACK: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_AK_A, 1'b0, 1'b1, 1'b1, LEN_2U};
                        end
                        default: begin
                            n_bit_cnt = r_bit_cnt;
                            n_poll    = r_poll;
                        end
                    endcase
                end
            end else if (r_phase == PH_WA_P) begin
                // acknowledge poll, one sample per tick
                if (!i_in.data.sda_in) begin
                    n_scl   = 1'b0;
                    n_err   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else if (r_poll == r_ack_timeout) begin
                    n_err  = 1'b1;
                    seg_go = 1'b1;
                    seg_v  = '{PH_SP_A, 1'b0, 1'b0, 1'b1, LEN_4U};
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end else begin
                // timed segment countdown
                n_delay = delay_dec;
                if (delay_dec == 12'd0) begin
                    unique case (r_phase)
                        PH_ST_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_ST_B, 1'b1, 1'b0, 1'b1, LEN_4U};
                        end
                        PH_ST_B: begin
                            n_scl   = 1'b0;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_SP_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_SP_B, 1'b1, 1'b1, 1'b1, LEN_4U};
                        end
                        PH_SP_B: begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_WR_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_WR_B, 1'b1, r_sda, 1'b1, LEN_2U};
                        end
                        PH_WR_B: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_WR_C, 1'b0, r_sda, 1'b1, LEN_2U};
                        end
                        PH_WR_C: begin
                            n_bit_cnt = bit_inc;
                            if (bit_inc < 4'd8) begin
                                seg_go  = 1'b1;
                                seg_v   = '{PH_WR_A, 1'b0, r_shift[7], 1'b1, LEN_2U};
                                n_shift = {r_shift[6:0], 1'b0};
                            end else begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                        PH_RD_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_RD_B, 1'b1, 1'b1, 1'b0, LEN_1U};
                        end
                        PH_RD_B: begin
                            n_shift   = rd_shift;
                            n_bit_cnt = bit_inc;
                            seg_go    = 1'b1;
                            if (bit_inc < 4'd8) begin
                                seg_v = '{PH_RD_A, 1'b0, 1'b1, 1'b0, LEN_2U};
                            end else begin
                                n_rx  = rd_shift;
                                seg_v = '{PH_AK_A, 1'b0, !r_ack_choice, 1'b1, LEN_2U};
                            end
                        end
                        PH_AK_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_AK_B, 1'b1, r_sda, 1'b1, LEN_2U};
                        end
                        PH_AK_B: begin
                            n_scl   = 1'b0;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_WA_A: begin
                            seg_go = 1'b1;
                            seg_v  = '{PH_WA_B, 1'b1, 1'b1, 1'b0, LEN_1U};
                        end
                        PH_WA_B: begin
                            n_phase = PH_WA_P;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end

            // entering a new pin segment
            if (seg_go) begin
                n_phase = seg_v.phase;
                n_scl   = seg_v.scl;
                n_sda   = seg_v.sda;
                n_en    = seg_v.en;
                n_delay = f_seg_delay(r_unit_ticks, seg_v.len);
            end
        end
    end

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg_data[9:0];
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 4'd0;
            r_shift      <= 8'd0;
            r_delay      <= 12'd0;
            r_poll       <= 8'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_en         <= 1'b1;
            r_err        <= 1'b0;
            r_rx         <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_en         <= n_en;
            r_err        <= n_err;
            r_rx         <= n_rx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.scl_level    <= n_scl;
            r_out.sda_level    <= n_en ? n_sda : 1'b1;
            r_out.sda_drive_en <= n_en;
            r_out.busy_res     <= (n_phase != PH_IDLE);
            r_out.done_res     <= done;
            r_out.rx_byte      <= n_rx;
            r_out.ack_error    <= n_err;
        end
    end

endmodule
